// ===== design/sha_pkg.sv =====
// ============================================================================
// sha_pkg
// Shared types, constants and round functions for the SHA-256 hasher.
// ============================================================================
package sha_pkg;

  localparam int unsigned QueueDepth = 4;

  // Input item as it travels from the front part to the back part
  typedef struct packed {
    logic [31:0] data;
    logic [2:0]  nbytes;
    logic        last;
  } sha_item_t;

  typedef logic [31:0] word_t;

  function automatic word_t round_k(input logic [5:0] idx);
    word_t k;
    case (idx)
      6'd0: k = 32'h428a2f98;  6'd1: k = 32'h71374491;  6'd2: k = 32'hb5c0fbcf;
      6'd3: k = 32'he9b5dba5;  6'd4: k = 32'h3956c25b;  6'd5: k = 32'h59f111f1;
      6'd6: k = 32'h923f82a4;  6'd7: k = 32'hab1c5ed5;  6'd8: k = 32'hd807aa98;
      6'd9: k = 32'h12835b01;  6'd10: k = 32'h243185be; 6'd11: k = 32'h550c7dc3;
      6'd12: k = 32'h72be5d74; 6'd13: k = 32'h80deb1fe; 6'd14: k = 32'h9bdc06a7;
      6'd15: k = 32'hc19bf174; 6'd16: k = 32'he49b69c1; 6'd17: k = 32'hefbe4786;
      6'd18: k = 32'h0fc19dc6; 6'd19: k = 32'h240ca1cc; 6'd20: k = 32'h2de92c6f;
      6'd21: k = 32'h4a7484aa; 6'd22: k = 32'h5cb0a9dc; 6'd23: k = 32'h76f988da;
      6'd24: k = 32'h983e5152; 6'd25: k = 32'ha831c66d; 6'd26: k = 32'hb00327c8;
      6'd27: k = 32'hbf597fc7; 6'd28: k = 32'hc6e00bf3; 6'd29: k = 32'hd5a79147;
      6'd30: k = 32'h06ca6351; 6'd31: k = 32'h14292967; 6'd32: k = 32'h27b70a85;
      6'd33: k = 32'h2e1b2138; 6'd34: k = 32'h4d2c6dfc; 6'd35: k = 32'h53380d13;
      6'd36: k = 32'h650a7354; 6'd37: k = 32'h766a0abb; 6'd38: k = 32'h81c2c92e;
      6'd39: k = 32'h92722c85; 6'd40: k = 32'ha2bfe8a1; 6'd41: k = 32'ha81a664b;
      6'd42: k = 32'hc24b8b70; 6'd43: k = 32'hc76c51a3; 6'd44: k = 32'hd192e819;
      6'd45: k = 32'hd6990624; 6'd46: k = 32'hf40e3585; 6'd47: k = 32'h106aa070;
      6'd48: k = 32'h19a4c116; 6'd49: k = 32'h1e376c08; 6'd50: k = 32'h2748774c;
      6'd51: k = 32'h34b0bcb5; 6'd52: k = 32'h391c0cb3; 6'd53: k = 32'h4ed8aa4a;
      6'd54: k = 32'h5b9cca4f; 6'd55: k = 32'h682e6ff3; 6'd56: k = 32'h748f82ee;
      6'd57: k = 32'h78a5636f; 6'd58: k = 32'h84c87814; 6'd59: k = 32'h8cc70208;
      6'd60: k = 32'h90befffa; 6'd61: k = 32'ha4506ceb; 6'd62: k = 32'hbef9a3f7;
      default: k = 32'hc67178f2;
    endcase
    return k;
  endfunction

  function automatic word_t init_hash(input logic [2:0] idx);
    word_t h;
    case (idx)
      3'd0: h = 32'h6a09e667; 3'd1: h = 32'hbb67ae85;
      3'd2: h = 32'h3c6ef372; 3'd3: h = 32'ha54ff53a;
      3'd4: h = 32'h510e527f; 3'd5: h = 32'h9b05688c;
      3'd6: h = 32'h1f83d9ab; default: h = 32'h5be0cd19;
    endcase
    return h;
  endfunction

  function automatic word_t rotr(input word_t x, input int unsigned n);
    return (x >> n) | (x << (32 - n));
  endfunction

endpackage

// ===== design/sha_front.sv =====
// ============================================================================
// sha_front
// Accepts input items, drops empty non-last words and queues the rest.
// ============================================================================
module sha_front (
  input  logic              clk,
  input  logic              rst,
  input  logic              push,
  output logic              full,
  input  logic [31:0]       data_word,
  input  logic [2:0]        valid_bytes,
  input  logic              last_word,
  output logic              q_valid,
  output sha_pkg::sha_item_t q_item,
  input  logic              q_take
);
  import sha_pkg::*;

  localparam int unsigned PtrW = $clog2(QueueDepth);

  sha_item_t         mem [QueueDepth];
  logic [PtrW-1:0]   wr_ptr;
  logic [PtrW-1:0]   rd_ptr;
  logic [PtrW:0]     count;
  logic              keep;
  logic              do_wr;
  logic              do_rd;
  logic [2:0]        nb_clamped;

  // Clamp byte count; an empty non-last word has no effect at all
  assign nb_clamped = (valid_bytes > 3'd4) ? 3'd4 : valid_bytes;
  assign keep  = last_word | (nb_clamped != 3'd0);
  assign full  = (count == (PtrW+1)'(QueueDepth));
  assign do_wr = push & ~full & keep;
  assign do_rd = q_take & q_valid;
  assign q_valid = (count != '0);
  assign q_item  = mem[rd_ptr];

  // Queue storage
  always_ff @(posedge clk) begin
    if (do_wr) begin
      mem[wr_ptr] <= '{data: data_word, nbytes: nb_clamped, last: last_word};
    end
  end

  // Queue pointers
  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= '0;
      rd_ptr <= '0;
      count  <= '0;
    end else begin
      if (do_wr) wr_ptr <= wr_ptr + 1'b1;
      if (do_rd) rd_ptr <= rd_ptr + 1'b1;
      count <= count + (PtrW+1)'(do_wr) - (PtrW+1)'(do_rd);
    end
  end

endmodule

// ===== design/sha_core.sv =====
// ============================================================================
// sha_core
// Byte packer, padding sequencer, one-round-per-cycle compression and
// digest output register.
// ============================================================================
module sha_core (
  input  logic              clk,
  input  logic              rst,
  input  logic              q_valid,
  input  sha_pkg::sha_item_t q_item,
  output logic              q_take,
  output logic              empty,
  input  logic              pop,
  output logic [31:0]       digest_word,
  output logic [2:0]        word_index,
  output logic              digest_end
);
  import sha_pkg::*;

  localparam logic [2:0] S_IDLE  = 3'd0;
  localparam logic [2:0] S_BYTE  = 3'd1;
  localparam logic [2:0] S_PAD   = 3'd2;
  localparam logic [2:0] S_ROUND = 3'd3;
  localparam logic [2:0] S_ADD   = 3'd4;
  localparam logic [2:0] S_OUT   = 3'd5;

  logic [2:0]  state;
  sha_item_t   cur;
  logic [2:0]  bidx;
  logic        padding;
  logic        final_blk;
  logic [63:0] message_bits;
  logic [63:0] len;
  word_t       w [16];
  word_t       hv [8];
  word_t       v [8];
  logic [5:0]  rnd;
  logic [3:0]  oidx;
  logic        out_full;

  logic [5:0]  pos;
  logic [7:0]  in_byte;
  logic [7:0]  pad_byte;
  word_t       s0, s1, w_new, t1, t2;
  logic [1:0]  bsel;

  assign pos  = message_bits[8:3];
  assign bsel = pos[1:0];
  assign in_byte = cur.data[31 - 8*bidx -: 8];
  assign q_take = (state == S_IDLE) && q_valid;
  assign empty  = ~out_full;

  // Message schedule: window of 16 words, shifted each round
  assign s0 = rotr(w[1], 7) ^ rotr(w[1], 18) ^ (w[1] >> 3);
  assign s1 = rotr(w[14], 17) ^ rotr(w[14], 19) ^ (w[14] >> 10);
  assign w_new = s1 + w[9] + s0 + w[0];

  // Round datapath
  always_comb begin
    word_t big1, ch, big0, maj;
    big1 = rotr(v[4], 6) ^ rotr(v[4], 11) ^ rotr(v[4], 25);
    ch   = (v[4] & v[5]) ^ (~v[4] & v[6]);
    t1   = v[7] + big1 + ch + round_k(rnd) + w[0];
    big0 = rotr(v[0], 2) ^ rotr(v[0], 13) ^ rotr(v[0], 22);
    maj  = (v[0] & v[1]) ^ (v[0] & v[2]) ^ (v[1] & v[2]);
    t2   = big0 + maj;
  end

  // Padding byte: 0x80 first, then zeros
  assign pad_byte = padding ? 8'h00 : 8'h80;

  // Sequencer
  always_ff @(posedge clk) begin
    if (rst) begin
      state        <= S_IDLE;
      message_bits <= '0;
      out_full     <= 1'b0;
      for (int i = 0; i < 8; i++) hv[i] <= init_hash(3'(i));
    end else begin
      // output register frees on pop unless reloaded this cycle
      if (out_full && pop && !(state == S_OUT && !oidx[3])) out_full <= 1'b0;
      case (state)
        S_IDLE: begin
          if (q_valid) begin
            cur   <= q_item;
            bidx  <= '0;
            state <= S_BYTE;
          end
        end
        // One message byte a cycle, paused while a full block is compressed
        S_BYTE: begin
          if (bidx == cur.nbytes) begin
            if (cur.last) begin
              len     <= message_bits;
              padding <= 1'b0;
              state   <= S_PAD;
            end else begin
              state <= S_IDLE;
            end
          end else begin
            if (bsel == 2'd0) w[pos[5:2]] <= {in_byte, 24'h0};
            else w[pos[5:2]][31 - 8*bsel -: 8] <= in_byte;
            message_bits <= message_bits + 64'd8;
            bidx <= bidx + 3'd1;
            if (pos == 6'd63) begin
              final_blk <= 1'b0;
              padding   <= 1'b0;
              rnd   <= '0;
              for (int i = 0; i < 8; i++) v[i] <= hv[i];
              state <= S_ROUND;
            end
          end
        end
        // Pad one byte a cycle, paused while a full block is compressed; length goes into the last two words
        S_PAD: begin
          padding <= 1'b1;
          if (bsel == 2'd0) w[pos[5:2]] <= {pad_byte, 24'h0};
          else w[pos[5:2]][31 - 8*bsel -: 8] <= pad_byte;
          message_bits <= message_bits + 64'd8;
          if (pos == 6'd63) begin
            final_blk <= 1'b0;
            rnd   <= '0;
            for (int i = 0; i < 8; i++) v[i] <= hv[i];
            state <= S_ROUND;
          end else if (pos == 6'd55 && padding) begin
            w[14] <= len[63:32];
            w[15] <= len[31:0];
            final_blk <= 1'b1;
            rnd   <= '0;
            for (int i = 0; i < 8; i++) v[i] <= hv[i];
            state <= S_ROUND;
          end else if (pos == 6'd55) begin
            // 0x80 itself lands on byte 55: length follows immediately
            w[14] <= len[63:32];
            w[15] <= len[31:0];
            final_blk <= 1'b1;
            rnd   <= '0;
            for (int i = 0; i < 8; i++) v[i] <= hv[i];
            state <= S_ROUND;
          end
        end
        // One round a cycle
        S_ROUND: begin
          v[7] <= v[6]; v[6] <= v[5]; v[5] <= v[4]; v[4] <= v[3] + t1;
          v[3] <= v[2]; v[2] <= v[1]; v[1] <= v[0]; v[0] <= t1 + t2;
          for (int i = 0; i < 15; i++) w[i] <= w[i+1];
          w[15] <= w_new;
          rnd <= rnd + 6'd1;
          if (rnd == 6'd63) state <= S_ADD;
        end
        // Fold in; the final block goes to output, a padding block carries on padding, a data block packs on
        S_ADD: begin
          for (int i = 0; i < 8; i++) hv[i] <= hv[i] + v[i];
          if (final_blk) begin
            oidx  <= '0;
            state <= S_OUT;
          end else if (padding) begin
            state <= S_PAD;
          end else begin
            state <= S_BYTE;
          end
        end
        // Hand out eight digest words through the output register
        S_OUT: begin
          if (!out_full || pop) begin
            if (oidx[3]) begin
              message_bits <= '0;
              for (int i = 0; i < 8; i++) hv[i] <= init_hash(3'(i));
              state <= S_IDLE;
            end else begin
              out_full    <= 1'b1;
              digest_word <= hv[oidx[2:0]];
              word_index  <= oidx[2:0];
              digest_end  <= (oidx[2:0] == 3'd7);
              oidx        <= oidx + 4'd1;
            end
          end
        end
        default: state <= S_IDLE;
      endcase
    end
  end

endmodule

// ===== design/sha256_message_hasher.sv =====
// ============================================================================
// sha256_message_hasher
// Streaming SHA-256 of a byte message given as big-endian words.
// ============================================================================
//  channel | handshake        | payload
//  input   | push / full      | data_word, valid_bytes, last_word
//  result  | pop / empty      | digest_word, word_index, digest_end
//
//  An item is taken from the queue, its valid bytes are packed one a cycle
//  and a final step finishes it; a full block pauses packing for the
//  compression rounds, one per cycle, plus the final add.
//  Padding goes one pad byte a cycle, paused while a block is compressed; the
//  digest leaves one word a cycle while pop is held, then the core restarts.
//  A four-item queue lets input be taken while the core compresses.
//  Reset (rst, synchronous) restores the initial hash and empties the queue.
module sha256_message_hasher (
  input  logic        clk,
  input  logic        rst,
  input  logic        push,
  output logic        full,
  input  logic [31:0] data_word,
  input  logic [2:0]  valid_bytes,
  input  logic        last_word,
  output logic        empty,
  input  logic        pop,
  output logic [31:0] digest_word,
  output logic [2:0]  word_index,
  output logic        digest_end
);
  import sha_pkg::*;

  logic      q_valid;
  logic      q_take;
  sha_item_t q_item;

  sha_front u_front (
    .clk, .rst, .push, .full, .data_word, .valid_bytes, .last_word,
    .q_valid, .q_item, .q_take
  );

  sha_core u_core (
    .clk, .rst, .q_valid, .q_item, .q_take,
    .empty, .pop, .digest_word, .word_index, .digest_end
  );

endmodule
